@@ rtl/paletted_texel_decoder_top_macros.svh @@
// Assertion macros for the paletted texel decoder.
// Needs signals clk and rst_n in the scope of use.
`ifndef PALETTED_TEXEL_DECODER_TOP_MACROS_SVH
`define PALETTED_TEXEL_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PTD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PTD_ASSERT_SAME(lbl, ante, cons)
`define PTD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/ptd_pkg.sv @@
// Package for the paletted texel decoder: field widths, format codes, alpha constants.
// No dependencies.
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int CODE_W   = 8;
    localparam int COLOUR_W = 16;
    localparam int ALPHA_W  = 8;
    localparam int FMT_W    = 2;
    localparam int PAL_DEPTH = 256;

    // texel_format codes
    localparam logic [FMT_W-1:0] FMT_A3I5   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_A5I3   = 2'd1;
    localparam logic [FMT_W-1:0] FMT_PAL256 = 2'd2;
    localparam logic [FMT_W-1:0] FMT_DIRECT = 2'd3;

    // item kinds
    localparam logic KIND_PAL_WRITE = 1'b0;
    localparam logic KIND_TEXEL     = 1'b1;

    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;
    localparam logic [ALPHA_W-1:0] ALPHA_MIN = 8'd0;

    // A3I5: alpha = (code & 0xE0) + 16, clamp at 239 and 16
    localparam logic [CODE_W-1:0]  A3I5_MASK = 8'hE0;
    localparam logic [ALPHA_W-1:0] A3I5_BIAS = 8'd16;
    localparam logic [ALPHA_W-1:0] A3I5_HI   = 8'd239;
    // A5I3: alpha = (code & 0xF8) + 4, clamp at 251 and 4
    localparam logic [CODE_W-1:0]  A5I3_MASK = 8'hF8;
    localparam logic [ALPHA_W-1:0] A5I3_BIAS = 8'd4;
    localparam logic [ALPHA_W-1:0] A5I3_HI   = 8'd251;

    localparam logic [COLOUR_W-1:0] COLOUR_TOP = 16'h8000;

    // Alpha per format; A3I5/A5I3 use the high code bits, sums stay below 256.
    function automatic logic [ALPHA_W-1:0] texel_alpha(
        input logic [FMT_W-1:0]  fmt,
        input logic [CODE_W-1:0] code,
        input logic              direct_top
    );
        logic [ALPHA_W-1:0] a;
        logic [ALPHA_W-1:0] res;
        begin
            a   = '0;
            res = ALPHA_MAX;
            case (fmt)
                FMT_A3I5:
                begin
                    a = (code & A3I5_MASK) + A3I5_BIAS;
                    if (a >= A3I5_HI)        res = ALPHA_MAX;
                    else if (a <= A3I5_BIAS) res = ALPHA_MIN;
                    else                     res = a;
                end
                FMT_A5I3:
                begin
                    a = (code & A5I3_MASK) + A5I3_BIAS;
                    if (a >= A5I3_HI)        res = ALPHA_MAX;
                    else if (a <= A5I3_BIAS) res = ALPHA_MIN;
                    else                     res = a;
                end
                FMT_PAL256: res = ALPHA_MAX;
                default:    res = direct_top ? ALPHA_MAX : ALPHA_MIN;
            endcase
            return res;
        end
    endfunction

    // Palette index taken from the texel byte.
    function automatic logic [CODE_W-1:0] palette_index(
        input logic [FMT_W-1:0]  fmt,
        input logic [CODE_W-1:0] code
    );
        logic [CODE_W-1:0] idx;
        begin
            case (fmt)
                FMT_A3I5: idx = {3'b000, code[4:0]};
                FMT_A5I3: idx = {5'b00000, code[2:0]};
                default:  idx = code;
            endcase
            return idx;
        end
    endfunction

endpackage

@@ rtl/ptd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ptd_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/paletted_texel_decoder_top.sv @@
// Paletted texel decoder, top level.
// Depends on ptd_pkg, ptd_ram and paletted_texel_decoder_top_macros.svh.
`timescale 1ns / 1ps

// Takes one item per clock while in_stall is low: palette writes (kind 0) store
// a colour into the 256 x 16 palette RAM and give no result; texel items
// (kind 1) give one colour/alpha result, decoded by texel_format (A3I5, A5I3,
// 256-colour, or direct 16-bit). The cycle of acceptance issues the palette
// read, the registered RAM output arrives in stage 1, and the result is loaded
// into the output register once stage 1 may advance. Throughput is one item per
// cycle while in_stall is low, set by the single read port and single write port
// of the palette RAM. A palette write lands at its acceptance edge, so any
// later texel reads the new colour. in_stall rises only when stage 1 holds a
// texel that cannot move into a full, stalled output register. texel_format
// should only be written while no items are in flight; cfg_ready is always high.
// Reading a palette entry that was never written returns undefined colour.

`include "paletted_texel_decoder_top_macros.svh"

module paletted_texel_decoder_top (
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ptd_pkg::FMT_W-1:0]     cfg_data,

    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [ptd_pkg::CODE_W-1:0]    palette_slot,
    input  logic [ptd_pkg::COLOUR_W-1:0]  palette_colour,
    input  logic [ptd_pkg::CODE_W-1:0]    texel_code,
    input  logic [ptd_pkg::COLOUR_W-1:0]  direct_colour,

    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ptd_pkg::COLOUR_W-1:0]  colour_out,
    output logic [ptd_pkg::ALPHA_W-1:0]   alpha_out
);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [ptd_pkg::FMT_W-1:0] fmt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= ptd_pkg::FMT_A3I5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fmt_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s1_adv;     // stage 1 may move into the output register
    logic in_accept;

    assign s1_adv    = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    // ---------------------------------------------------------------
    // Stage 0: palette write or palette read issue
    // ---------------------------------------------------------------
    logic                           pal_we;
    logic                           pal_re;
    logic [ptd_pkg::CODE_W-1:0]     pal_raddr;
    logic [ptd_pkg::COLOUR_W-1:0]   pal_rdata;

    assign pal_we    = in_accept && (kind == ptd_pkg::KIND_PAL_WRITE);
    assign pal_re    = in_accept && (kind == ptd_pkg::KIND_TEXEL);
    assign pal_raddr = ptd_pkg::palette_index(fmt_reg, texel_code);

    ptd_ram #(
        .DATA_W (ptd_pkg::COLOUR_W),
        .DEPTH  (ptd_pkg::PAL_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (palette_slot),
        .wdata (palette_colour),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    // Alpha and direct colour travel alongside the read.
    logic [ptd_pkg::ALPHA_W-1:0]  s1_alpha_reg, s1_alpha_next;
    logic [ptd_pkg::COLOUR_W-1:0] s1_direct_reg, s1_direct_next;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_alpha_next  = s1_alpha_reg;
        s1_direct_next = s1_direct_reg;
        if (!s1_valid_reg || s1_adv)
        begin
            s1_valid_next = pal_re;
        end
        if (pal_re)
        begin
            s1_alpha_next  = ptd_pkg::texel_alpha(fmt_reg, texel_code,
                                                  direct_colour[ptd_pkg::COLOUR_W-1]);
            s1_direct_next = direct_colour;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_alpha_reg  <= s1_alpha_next;
        s1_direct_reg <= s1_direct_next;
    end

    // ---------------------------------------------------------------
    // Stage 1: colour select into the output register
    // ---------------------------------------------------------------
    logic [ptd_pkg::COLOUR_W-1:0] s1_colour;
    logic [ptd_pkg::COLOUR_W-1:0] colour_reg, colour_next;
    logic [ptd_pkg::ALPHA_W-1:0]  alpha_reg, alpha_next;

    always_comb
    begin
        case (fmt_reg)
            ptd_pkg::FMT_A3I5:   s1_colour = pal_rdata;
            ptd_pkg::FMT_A5I3:   s1_colour = pal_rdata;
            ptd_pkg::FMT_PAL256: s1_colour = pal_rdata | ptd_pkg::COLOUR_TOP;
            default:             s1_colour = s1_direct_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        colour_next    = colour_reg;
        alpha_next     = alpha_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (s1_adv && s1_valid_reg)
        begin
            colour_next = s1_colour;
            alpha_next  = s1_alpha_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        colour_reg <= colour_next;
        alpha_reg  <= alpha_next;
    end

    assign out_valid  = out_valid_reg;
    assign colour_out = colour_reg;
    assign alpha_out  = alpha_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // an accepted texel always reaches stage 1
    `PTD_ASSERT_NEXT(a_texel_to_s1, pal_re, s1_valid_reg)
    // a held stage 1 keeps its RAM read data (direct mode ignores the read)
    `PTD_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_adv && (fmt_reg != ptd_pkg::FMT_DIRECT), s1_valid_reg && $stable(pal_rdata))
    // 256-colour results carry bit 15 and full alpha
    `PTD_ASSERT_SAME(a_pal256_out, out_valid_reg && (fmt_reg == ptd_pkg::FMT_PAL256), colour_reg[ptd_pkg::COLOUR_W-1] && (alpha_reg == ptd_pkg::ALPHA_MAX))

endmodule

@@ tb/sv/tb_paletted_texel_decoder_top.sv @@
// Self-checking testbench for paletted_texel_decoder_top: a directed table, then random
// items in all four texel formats, checked against a predictor built into this module.
// Depends on ptd_pkg and the RTL of paletted_texel_decoder_top.
`timescale 1ns / 1ps

module tb_paletted_texel_decoder_top;

    import ptd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;  // generous: under 1500 items with random gaps and stalls
    localparam int SETTLE_CYCLES = 8;       // covers the two-stage pipe plus the output register
    localparam int IDLE_PCT      = 13;
    localparam int N_DIRECTED    = 23;
    localparam int N_PHASES      = 8;
    localparam int PHASE_ITEMS   = 150;     // with palette preloads, about 1300 items in all

    // One decoded texel as it leaves the block.
    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic [ALPHA_W-1:0]  alpha;
    } texel_result_t;

    // One row of the directed table. When known is set, the result is typed in the
    // row; otherwise it comes from the predictor.
    typedef struct packed {
        logic [FMT_W-1:0]    fmt;
        logic                kind;
        logic [CODE_W-1:0]   slot;
        logic [COLOUR_W-1:0] pcol;
        logic [CODE_W-1:0]   code;
        logic [COLOUR_W-1:0] dcol;
        logic                known;
        logic [COLOUR_W-1:0] ecol;
        logic [ALPHA_W-1:0]  ealpha;
    } directed_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [FMT_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 kind;
    logic [CODE_W-1:0]    palette_slot;
    logic [COLOUR_W-1:0]  palette_colour;
    logic [CODE_W-1:0]    texel_code;
    logic [COLOUR_W-1:0]  direct_colour;
    logic                 out_valid;
    logic                 out_stall;
    logic [COLOUR_W-1:0]  colour_out;
    logic [ALPHA_W-1:0]   alpha_out;

    // Predictor state: our own copy of the palette and of texel_format.
    logic [COLOUR_W-1:0]  palette_copy [PAL_DEPTH];
    bit                   slot_loaded  [PAL_DEPTH];
    logic [FMT_W-1:0]     fmt_shadow;

    texel_result_t        pending_texels [$];   // decoded texels not yet seen at the output
    int unsigned          mismatches;
    int unsigned          cycle_count;
    bit                   quiet_stretch;        // no idling on either side while set

    // Directed part. Palette entries are loaded before any texel reads them, since
    // an unwritten entry has no defined colour.
    directed_row_t directed_rows [N_DIRECTED] = '{
        // palette loads under the reset format
        '{FMT_A3I5,   KIND_PAL_WRITE, 8'd0,   16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'd0},
        '{FMT_A3I5,   KIND_PAL_WRITE, 8'd31,  16'hFFFF, 8'hFF, 16'hFFFF, 1'b0, 16'h0000, 8'd0},
        '{FMT_A3I5,   KIND_PAL_WRITE, 8'd7,   16'h1234, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'd0},
        '{FMT_A3I5,   KIND_PAL_WRITE, 8'd255, 16'h8001, 8'h55, 16'hAAAA, 1'b0, 16'h0000, 8'd0},
        // A3I5: alpha floor, alpha ceiling, two middle values
        '{FMT_A3I5,   KIND_TEXEL,     8'hFF,  16'hFFFF, 8'h00, 16'hFFFF, 1'b1, 16'h0000, 8'd0},
        '{FMT_A3I5,   KIND_TEXEL,     8'h00,  16'h0000, 8'hFF, 16'h0000, 1'b1, 16'hFFFF, 8'd255},
        '{FMT_A3I5,   KIND_TEXEL,     8'h5A,  16'h0F0F, 8'h27, 16'h0000, 1'b0, 16'h0000, 8'd0},
        '{FMT_A3I5,   KIND_TEXEL,     8'h00,  16'h0000, 8'hC0, 16'h0000, 1'b0, 16'h0000, 8'd0},
        // A5I3: same corners with the 3-bit index
        '{FMT_A5I3,   KIND_TEXEL,     8'h00,  16'h0000, 8'h00, 16'h0000, 1'b1, 16'h0000, 8'd0},
        '{FMT_A5I3,   KIND_TEXEL,     8'h00,  16'h0000, 8'hFF, 16'h0000, 1'b1, 16'h1234, 8'd255},
        '{FMT_A5I3,   KIND_TEXEL,     8'h00,  16'h0000, 8'hF7, 16'h0000, 1'b0, 16'h0000, 8'd0},
        '{FMT_A5I3,   KIND_TEXEL,     8'h00,  16'h0000, 8'h08, 16'h0000, 1'b0, 16'h0000, 8'd0},
        // 256-colour: full index range, bit 15 forced
        '{FMT_PAL256, KIND_PAL_WRITE, 8'd128, 16'h5555, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'd0},
        '{FMT_PAL256, KIND_TEXEL,     8'h00,  16'h0000, 8'hFF, 16'h0000, 1'b1, 16'h8001, 8'd255},
        '{FMT_PAL256, KIND_TEXEL,     8'h00,  16'h0000, 8'h80, 16'h0000, 1'b0, 16'h0000, 8'd0},
        '{FMT_PAL256, KIND_TEXEL,     8'h00,  16'h0000, 8'h00, 16'h0000, 1'b1, 16'h8000, 8'd255},
        // direct: colour passes through, alpha follows bit 15
        '{FMT_DIRECT, KIND_TEXEL,     8'h00,  16'h0000, 8'h00, 16'hFFFF, 1'b1, 16'hFFFF, 8'd255},
        '{FMT_DIRECT, KIND_TEXEL,     8'hFF,  16'hFFFF, 8'hFF, 16'h0000, 1'b1, 16'h0000, 8'd0},
        '{FMT_DIRECT, KIND_TEXEL,     8'h00,  16'h0000, 8'h00, 16'h8000, 1'b1, 16'h8000, 8'd255},
        '{FMT_DIRECT, KIND_TEXEL,     8'h00,  16'h0000, 8'h00, 16'h7FFF, 1'b1, 16'h7FFF, 8'd0},
        // palette write while in direct mode still lands; code ignored in direct
        '{FMT_DIRECT, KIND_PAL_WRITE, 8'd1,   16'hA5A5, 8'h00, 16'h0000, 1'b0, 16'h0000, 8'd0},
        '{FMT_DIRECT, KIND_TEXEL,     8'h00,  16'h0000, 8'hFF, 16'h1357, 1'b0, 16'h0000, 8'd0},
        // back to A3I5 to read the entry loaded in direct mode
        '{FMT_A3I5,   KIND_TEXEL,     8'h00,  16'h0000, 8'h01, 16'h0000, 1'b0, 16'h0000, 8'd0}
    };

    paletted_texel_decoder_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .palette_slot   (palette_slot),
        .palette_colour (palette_colour),
        .texel_code     (texel_code),
        .direct_colour  (direct_colour),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .colour_out     (colour_out),
        .alpha_out      (alpha_out)
    );

    always #5 clk = ~clk;

    // Watchdog: any hang (lost result, stuck stall) ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** paletted_texel_decoder_top: FAILED **");
            $finish;
        end
    end

    // Texel decode as the format register says. Sums are kept one bit wider so the
    // clamps compare against the true value.
    function automatic texel_result_t decode_texel(input logic [CODE_W-1:0]   code,
                                                   input logic [COLOUR_W-1:0] dcol);
        texel_result_t  res;
        logic [ALPHA_W:0] a;
        begin
            res = '0;
            a   = '0;
            case (fmt_shadow)
                FMT_A3I5:
                begin
                    res.colour = palette_copy[code[4:0]];
                    a = {1'b0, code & A3I5_MASK} + A3I5_BIAS;
                    if (a >= A3I5_HI)        res.alpha = ALPHA_MAX;
                    else if (a <= A3I5_BIAS) res.alpha = ALPHA_MIN;
                    else                     res.alpha = a[ALPHA_W-1:0];
                end
                FMT_A5I3:
                begin
                    res.colour = palette_copy[code[2:0]];
                    a = {1'b0, code & A5I3_MASK} + A5I3_BIAS;
                    if (a >= A5I3_HI)        res.alpha = ALPHA_MAX;
                    else if (a <= A5I3_BIAS) res.alpha = ALPHA_MIN;
                    else                     res.alpha = a[ALPHA_W-1:0];
                end
                FMT_PAL256:
                begin
                    res.colour = palette_copy[code] | COLOUR_TOP;
                    res.alpha  = ALPHA_MAX;
                end
                default:
                begin
                    res.colour = dcol;
                    res.alpha  = dcol[COLOUR_W-1] ? ALPHA_MAX : ALPHA_MIN;
                end
            endcase
            return res;
        end
    endfunction

    task automatic log_mismatch(input string what, input texel_result_t want,
                                input texel_result_t got);
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s: expected colour %h alpha %h, got colour %h alpha %h",
                         $realtime, what, want.colour, want.alpha, got.colour, got.alpha);
        end
    endtask

    // Present one item from a falling edge, with random idle cycles ahead of it,
    // and hold it until the block takes it. The predictor runs at acceptance.
    task automatic send_item(input logic k, input logic [CODE_W-1:0] slot,
                             input logic [COLOUR_W-1:0] pcol, input logic [CODE_W-1:0] code,
                             input logic [COLOUR_W-1:0] dcol, input logic known,
                             input texel_result_t known_res);
        texel_result_t expected;
        begin
            while (!quiet_stretch && $urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid       <= 1'b1;
            kind           <= k;
            palette_slot   <= slot;
            palette_colour <= pcol;
            texel_code     <= code;
            direct_colour  <= dcol;
            do
                @(posedge clk);
            while (in_stall !== 1'b0);
            if (k == KIND_PAL_WRITE)
            begin
                palette_copy[slot] = pcol;
                slot_loaded[slot]  = 1'b1;
            end
            else
            begin
                expected       = known ? known_res : decode_texel(code, dcol);
                pending_texels = {pending_texels, expected};
            end
            @(negedge clk);
        end
    endtask

    // Drop valid, wait out every pending texel, then let the pipe empty behind
    // trailing palette writes. Returns at a falling edge.
    task automatic settle_pipeline();
        begin
            in_valid <= 1'b0;
            while (pending_texels.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // Format writes only go in with the block idle.
    task automatic apply_format(input logic [FMT_W-1:0] f);
        begin
            settle_pipeline();
            cfg_valid <= 1'b1;
            cfg_data  <= f;
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
            fmt_shadow = f;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // Result side: random stalls driven at the falling edge.
    always @(negedge clk)
        out_stall <= !quiet_stretch && ($urandom_range(99) < IDLE_PCT);

    // Every result taken is checked against the oldest pending texel.
    always @(posedge clk)
    begin
        texel_result_t got;
        texel_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{colour_out, alpha_out};
            if (pending_texels.size() == 0)
                log_mismatch("result with no texel pending", '0, got);
            else
            begin
                want = pending_texels.pop_front();
                if (got.colour !== want.colour || got.alpha !== want.alpha)
                    log_mismatch("texel result mismatch", want, got);
            end
        end
    end

    initial
    begin
        logic [FMT_W-1:0]  phase_fmts [4];
        logic [FMT_W-1:0]  fmt;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] idx;
        directed_row_t     row;

        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = FMT_A3I5;
        in_valid       = 1'b0;
        kind           = KIND_PAL_WRITE;
        palette_slot   = '0;
        palette_colour = '0;
        texel_code     = '0;
        direct_colour  = '0;
        out_stall      = 1'b0;
        mismatches     = 0;
        cycle_count    = 0;
        quiet_stretch  = 1'b0;
        fmt_shadow     = FMT_A3I5;
        foreach (palette_copy[i])
        begin
            palette_copy[i] = '0;
            slot_loaded[i]  = 1'b0;
        end

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table; the format changes between rows are done with the pipe idle.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = directed_rows[i];
            if (row.fmt != fmt_shadow)
                apply_format(row.fmt);
            send_item(row.kind, row.slot, row.pcol, row.code, row.dcol, row.known,
                      '{row.ecol, row.ealpha});
        end

        // Random phases. The first four cover every format;
        // phase 4 runs with no idling on either side.
        phase_fmts = '{FMT_DIRECT, FMT_A5I3, FMT_A3I5, FMT_PAL256};
        for (int p = 0; p < N_PHASES; p++)
        begin
            fmt = (p < 4) ? phase_fmts[p] : FMT_W'($urandom_range(3));
            apply_format(fmt);
            quiet_stretch = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 25)
                    send_item(KIND_PAL_WRITE, CODE_W'($urandom), COLOUR_W'($urandom),
                              CODE_W'($urandom), COLOUR_W'($urandom), 1'b0, '0);
                else
                begin
                    code = CODE_W'($urandom);
                    case (fmt)
                        FMT_A3I5: idx = {3'b000, code[4:0]};
                        FMT_A5I3: idx = {5'b00000, code[2:0]};
                        default:  idx = code;
                    endcase
                    // load the entry first if this texel would read it unwritten
                    if (fmt != FMT_DIRECT && !slot_loaded[idx])
                        send_item(KIND_PAL_WRITE, idx, COLOUR_W'($urandom),
                                  CODE_W'($urandom), COLOUR_W'($urandom), 1'b0, '0);
                    send_item(KIND_TEXEL, CODE_W'($urandom), COLOUR_W'($urandom), code,
                              COLOUR_W'($urandom), 1'b0, '0);
                end
            end
            quiet_stretch = 1'b0;
        end

        settle_pipeline();
        if (mismatches == 0 && pending_texels.size() == 0)
            $display("** paletted_texel_decoder_top: PASSED **");
        else
            $display("** paletted_texel_decoder_top: FAILED **");
        $finish;
    end

endmodule

@@ paletted_texel_decoder_top.f @@
+incdir+rtl
rtl/ptd_pkg.sv
rtl/ptd_ram.sv
rtl/paletted_texel_decoder_top.sv
tb/sv/tb_paletted_texel_decoder_top.sv
